>>> design/load_factor_governor_defines.svh
// Assertion macros used by the governor RTL.
`ifndef LOAD_FACTOR_GOVERNOR_DEFINES_SVH
`define LOAD_FACTOR_GOVERNOR_DEFINES_SVH

`ifndef SYNTH

// Check that ante implies cons in the same cycle.
`define LFG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("governor check failed");

// Check that ante implies cons in the following cycle.
`define LFG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("governor check failed");

`else

`define LFG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LFG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/lfg_pkg.sv
package lfg_pkg;

  // Peer table and load stepping
  localparam int PEER_SLOTS  = 8;
  localparam int LOAD_STEP   = 1;
  localparam int LOAD_START  = 1;
  localparam int SAT_CPU_PCT = 90;

  typedef logic [31:0] ms_t;
  typedef logic [1:0]  level_t;

  // Item opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Stress codes, shared by own stress and peer reports
  localparam level_t STRESS_LO  = 2'd0;
  localparam level_t STRESS_MED = 2'd1;
  localparam level_t STRESS_HI  = 2'd2;

  // Run state codes
  localparam logic [1:0] RUN_SCHED = 2'd0;
  localparam logic [1:0] RUN_OVER  = 2'd1;
  localparam logic [1:0] RUN_SAT   = 2'd2;

  // Load change codes
  localparam logic [1:0] CHANGE_NONE = 2'd0;
  localparam logic [1:0] CHANGE_DEC  = 2'd1;
  localparam logic [1:0] CHANGE_INC  = 2'd2;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_EXEC_THR,
    REG_CPU_THR,
    REG_LOAD_MIN,
    REG_LOAD_MAX,
    REG_LOW_WIN,
    REG_PEER_TMO,
    REG_ADJ_INT,
    REG_DEC_EN
  } cfg_reg_t;

  // Token passed along the peer cell row during an ageing sweep
  typedef struct packed {
    logic pulse;
    logic low_peer;
    logic high_peer;
  } scan_t;

  // Ageing controls broadcast to every cell
  typedef struct packed {
    ms_t         now;
    logic [15:0] timeout;
    logic        dec_en;
  } age_ctl_t;

endpackage

>>> design/lfg_item_if.sv
interface lfg_item_if;
  import lfg_pkg::*;

  logic        valid;
  logic        ready;
  logic        opcode;
  ms_t         now_ms;
  logic        stats_ready;
  logic [15:0] exec_peak;
  logic [15:0] miss_count;
  logic [6:0]  cpu_pct;
  logic [3:0]  active_channels;
  logic [2:0]  peer_index;
  level_t      peer_stress;

  modport source (
    output valid, opcode, now_ms, stats_ready, exec_peak, miss_count, cpu_pct,
           active_channels, peer_index, peer_stress,
    input  ready
  );

  modport sink (
    input  valid, opcode, now_ms, stats_ready, exec_peak, miss_count, cpu_pct,
           active_channels, peer_index, peer_stress,
    output ready
  );
endinterface

>>> design/lfg_result_if.sv
interface lfg_result_if;
  import lfg_pkg::*;

  logic       valid;
  logic       ready;
  level_t     stress_out;
  logic       offload_request;
  logic [1:0] run_state;
  logic [7:0] load_out;
  logic [1:0] load_change;

  modport source (
    output valid, stress_out, offload_request, run_state, load_out, load_change,
    input  ready
  );

  modport sink (
    input  valid, stress_out, offload_request, run_state, load_out, load_change,
    output ready
  );
endinterface

>>> design/lfg_peer_cell.sv
module lfg_peer_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  lfg_pkg::level_t   wr_level,
  input  lfg_pkg::ms_t      wr_time,
  input  lfg_pkg::age_ctl_t ctl,
  input  lfg_pkg::scan_t    scan_in,
  output lfg_pkg::scan_t    scan_out
);
  import lfg_pkg::*;

  logic   valid;
  level_t level;
  ms_t    seen;
  ms_t    age;
  logic   stale;
  logic   live;

  // Age of this slot against the tick time, modulo 2^32
  assign age   = ctl.now - seen;
  assign stale = age > {16'b0, ctl.timeout};
  assign live  = scan_in.pulse && valid && !stale;

  // Hold the valid bit; set on a report, drop when the sweep finds it stale
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end else if (scan_in.pulse && valid && stale) begin
      valid <= 1'b0;
    end
  end

  // Store the reported level and time
  always_ff @(posedge clk) begin
    if (wr) begin
      level <= wr_level;
      seen  <= wr_time;
    end
  end

  // Advance the sweep token, folding in this slot's flags
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out.pulse     <= scan_in.pulse;
      scan_out.low_peer  <= scan_in.low_peer
                            | (live && ctl.dec_en && (level == STRESS_LO));
      scan_out.high_peer <= scan_in.high_peer | (live && (level == STRESS_HI));
    end
  end
endmodule

>>> design/load_factor_governor.sv
// Channel   Dir   Word carried
// item      in    opcode, now_ms, window stats, cpu, channels, peer slot and stress
// result    out   stress_out, offload_request, run_state, load_out, load_change
// cfg_*     in    write enable, register index, 16-bit data
//
// A peer report leaves the block idle and gives no result.
// A tick is latched on acceptance; the ageing token then walks the row of peer
// cells one slot a cycle, ST_SCAN latches the peer flags and ST_ADJ adjusts and
// posts the result; the next word is taken once that adjustment has committed.
// Reset is synchronous: all peer slots invalid, load factor at LOAD_START.
// The result sits in an output register; while it stalls, reports and the next
// tick's sweep still go ahead, and only the next tick's result waits for it.
`include "load_factor_governor_defines.svh"

module load_factor_governor (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  lfg_item_if.sink     item,
  lfg_result_if.source result
);
  import lfg_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_ADJ} state_t;

  // Configuration registers
  logic [15:0] exec_thr;
  logic [6:0]  cpu_thr;
  logic [7:0]  load_min;
  logic [7:0]  load_max;
  logic [7:0]  low_win;
  logic [15:0] peer_tmo;
  logic [15:0] adj_int;
  logic        dec_en;

  // Governor state
  state_t      state;
  logic        launch;
  ms_t         tick_now;
  logic [6:0]  tick_cpu;
  logic [3:0]  tick_chans;
  logic        tick_ready;
  logic [15:0] held_exec;
  logic [15:0] held_miss;
  logic [7:0]  load_value;
  logic [7:0]  low_streak;
  ms_t         last_adjust;
  logic        low_peer;
  logic        high_peer;

  // Output register
  logic        result_valid;
  level_t      result_stress;
  logic        result_offload;
  logic [1:0]  result_run;
  logic [7:0]  result_load;
  logic [1:0]  result_change;
  logic        res_inc;
  logic        res_dec;

  // Handshake and sweep
  logic        accept;
  logic        tick_acc;
  logic        rep_acc;
  logic        commit;
  age_ctl_t    ctl;
  scan_t       chain [PEER_SLOTS+1];
  scan_t       tail;

  // Adjustment logic
  level_t      stress;
  logic [1:0]  run_code;
  logic        interval_ok;
  logic        dec_path;
  logic        inc_path;
  logic [7:0]  streak_inc;
  logic [8:0]  lv9;
  logic [8:0]  step9;
  logic [8:0]  dn9;
  logic [8:0]  up9;
  logic [7:0]  load_next;
  logic [7:0]  streak_next;
  ms_t         last_next;
  logic [1:0]  change;

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign tick_acc   = accept && (item.opcode == OP_TICK);
  assign rep_acc    = accept && (item.opcode == OP_REPORT);
  assign commit     = (state == ST_ADJ) && (!result_valid || result.ready);

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      exec_thr <= 16'd100;
      cpu_thr  <= 7'd85;
      load_min <= 8'd1;
      load_max <= 8'd100;
      low_win  <= 8'd3;
      peer_tmo <= 16'd5000;
      adj_int  <= 16'd2000;
      dec_en   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EXEC_THR: exec_thr <= cfg_data;
        REG_CPU_THR:  cpu_thr  <= cfg_data[6:0];
        REG_LOAD_MIN: load_min <= cfg_data[7:0];
        REG_LOAD_MAX: load_max <= cfg_data[7:0];
        REG_LOW_WIN:  low_win  <= cfg_data[7:0];
        REG_PEER_TMO: peer_tmo <= cfg_data;
        REG_ADJ_INT:  adj_int  <= cfg_data;
        REG_DEC_EN:   dec_en   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Row of peer cells; the token enters at slot 0 the cycle after a tick
  assign chain[0] = '{pulse: launch, low_peer: 1'b0, high_peer: 1'b0};
  assign ctl      = '{now: tick_now, timeout: peer_tmo, dec_en: dec_en};
  assign tail     = chain[PEER_SLOTS];

  for (genvar i = 0; i < PEER_SLOTS; i++) begin : g_slot
    logic sel;
    assign sel = rep_acc && (int'(item.peer_index) == i);

    lfg_peer_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (sel),
      .wr_level (item.peer_stress),
      .wr_time  (item.now_ms),
      .ctl      (ctl),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1])
    );
  end

  // Classify own stress and pick the adjustment branch
  always_comb begin
    if (held_miss != 16'd0) begin
      stress = STRESS_HI;
    end else if ((held_exec > exec_thr) || (tick_cpu > cpu_thr)) begin
      stress = STRESS_MED;
    end else begin
      stress = STRESS_LO;
    end

    if (held_miss != 16'd0) begin
      run_code = RUN_OVER;
    end else if (tick_cpu >= 7'(SAT_CPU_PCT)) begin
      run_code = RUN_SAT;
    end else begin
      run_code = RUN_SCHED;
    end

    interval_ok = tick_ready && ((tick_now - last_adjust) >= {16'b0, adj_int});
    dec_path    = dec_en && (stress == STRESS_HI) && low_peer && (tick_chans == 4'd0);
    inc_path    = !dec_path && (stress == STRESS_LO) && !high_peer;
    streak_inc  = (low_streak == 8'hFF) ? low_streak : low_streak + 8'd1;

    lv9   = {1'b0, load_value};
    step9 = 9'(LOAD_STEP);
    dn9   = (lv9 > step9) ? lv9 - step9 : {1'b0, load_min};
    if (dn9 < {1'b0, load_min}) begin
      dn9 = {1'b0, load_min};
    end
    up9 = lv9 + step9;
    if (up9 > {1'b0, load_max}) begin
      up9 = {1'b0, load_max};
    end

    load_next   = load_value;
    streak_next = low_streak;
    last_next   = last_adjust;
    change      = CHANGE_NONE;
    if (interval_ok) begin
      priority if (dec_path) begin
        if (load_value > load_min) begin
          load_next   = dn9[7:0];
          last_next   = tick_now;
          streak_next = 8'd0;
          change      = CHANGE_DEC;
        end
      end else if (inc_path) begin
        streak_next = streak_inc;
        if ((streak_inc >= low_win) && (load_value < load_max)) begin
          load_next   = up9[7:0];
          last_next   = tick_now;
          streak_next = 8'd0;
          change      = CHANGE_INC;
        end
      end else begin
        streak_next = 8'd0;
      end
    end
  end

  // Sequence a tick: latch, sweep the peer row, adjust and post the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      launch       <= 1'b0;
      held_exec    <= 16'd0;
      held_miss    <= 16'd0;
      load_value   <= 8'(LOAD_START);
      low_streak   <= 8'd0;
      last_adjust  <= '0;
      result_valid <= 1'b0;
    end else begin
      launch <= tick_acc;
      // Raise the result on a commit, drop it once taken
      if (commit) begin
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (tick_acc) begin
            tick_now   <= item.now_ms;
            tick_cpu   <= item.cpu_pct;
            tick_chans <= item.active_channels;
            tick_ready <= item.stats_ready;
            if (item.stats_ready) begin
              held_exec <= item.exec_peak;
              held_miss <= item.miss_count;
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail.pulse) begin
            low_peer  <= tail.low_peer;
            high_peer <= tail.high_peer;
            state     <= ST_ADJ;
          end
        end
        ST_ADJ: begin
          if (commit) begin
            load_value     <= load_next;
            low_streak     <= streak_next;
            last_adjust    <= last_next;
            result_stress  <= stress;
            result_offload <= (stress != STRESS_LO);
            result_run     <= run_code;
            result_load    <= load_next;
            result_change  <= change;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid           = result_valid;
  assign result.stress_out      = result_stress;
  assign result.offload_request = result_offload;
  assign result.run_state       = result_run;
  assign result.load_out        = result_load;
  assign result.load_change     = result_change;

  assign res_inc = result_valid && (result_change == CHANGE_INC);
  assign res_dec = result_valid && (result_change == CHANGE_DEC);

  `LFG_ASSERT_IMPL(a_tail_in_scan, clk, rst, tail.pulse, state == ST_SCAN)
  `LFG_ASSERT_NEXT(a_tick_launches, clk, rst, tick_acc, launch && (state == ST_SCAN))
  `LFG_ASSERT_IMPL(a_inc_bounded, clk, rst, res_inc, result_load <= load_max)
  `LFG_ASSERT_IMPL(a_dec_bounded, clk, rst, res_dec, result_load >= load_min)
endmodule

>>> tb/load_factor_governor_tb.sv
module load_factor_governor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfg_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int TICK_LATENCY    = PEER_SLOTS + 3;
  localparam int SETTLE_CYCLES   = 4 * TICK_LATENCY;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 600000;

  // Register indexes past the last real register
  localparam logic [3:0] REG_SPARE_FIRST = 4'd8;
  localparam logic [3:0] REG_SPARE_LAST  = 4'd15;

  // Peer stress code that is neither low nor high
  localparam level_t STRESS_UNUSED = 2'd3;

  typedef struct packed {
    logic        opcode;
    ms_t         now_ms;
    logic        stats_ready;
    logic [15:0] exec_peak;
    logic [15:0] miss_count;
    logic [6:0]  cpu_pct;
    logic [3:0]  active_channels;
    logic [2:0]  peer_index;
    level_t      peer_stress;
  } gov_word_t;

  typedef struct packed {
    level_t     stress_out;
    logic       offload_request;
    logic [1:0] run_state;
    logic [7:0] load_out;
    logic [1:0] load_change;
  } verdict_t;

  typedef enum logic [1:0] {PACE_FREE, PACE_LIGHT, PACE_HALF, PACE_HEAVY} pace_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;

  lfg_item_if   item_ch ();
  lfg_result_if result_ch ();

  load_factor_governor dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // Shadow copy of the governor settings
  logic [15:0] thr_exec;
  logic [6:0]  thr_cpu;
  logic [7:0]  floor_load;
  logic [7:0]  ceil_load;
  logic [7:0]  calm_needed;
  logic [15:0] slot_tmo;
  logic [15:0] step_gap_ms;
  logic        shed_en;

  // Shadow copy of the governor state
  logic [15:0] seen_exec;
  logic [15:0] seen_miss;
  logic [7:0]  load_now;
  logic [7:0]  calm_run;
  ms_t         last_step_ms;
  logic        slot_live     [PEER_SLOTS];
  level_t      slot_level    [PEER_SLOTS];
  ms_t         slot_heard_ms [PEER_SLOTS];

  verdict_t verdicts_due [$];
  int       errors;
  int       cycles;
  bit       hold_off_req;
  ms_t      clock_ms;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("** load_factor_governor: FAILED **");
      $finish;
    end
  end

  function automatic void shadow_reset();
    thr_exec     = 16'd100;
    thr_cpu      = 7'd85;
    floor_load   = 8'd1;
    ceil_load    = 8'd100;
    calm_needed  = 8'd3;
    slot_tmo     = 16'd5000;
    step_gap_ms  = 16'd2000;
    shed_en      = 1'b1;
    seen_exec    = '0;
    seen_miss    = '0;
    load_now     = 8'(LOAD_START);
    calm_run     = '0;
    last_step_ms = '0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      slot_live[i]     = 1'b0;
      slot_level[i]    = STRESS_LO;
      slot_heard_ms[i] = '0;
    end
  endfunction

  function automatic void shadow_config(input logic [3:0] idx, input logic [15:0] data);
    case (idx)
      REG_EXEC_THR: thr_exec    = data;
      REG_CPU_THR:  thr_cpu     = data[6:0];
      REG_LOAD_MIN: floor_load  = data[7:0];
      REG_LOAD_MAX: ceil_load   = data[7:0];
      REG_LOW_WIN:  calm_needed = data[7:0];
      REG_PEER_TMO: slot_tmo    = data;
      REG_ADJ_INT:  step_gap_ms = data;
      REG_DEC_EN:   shed_en     = data[0];
      default: ;
    endcase
  endfunction

  // Advance the shadow governor by one accepted word; a tick queues a verdict
  function automatic void govern(input gov_word_t w);
    verdict_t v;
    level_t   stress;
    logic     low_peer;
    logic     high_peer;
    int       next_load;
    if (w.opcode == OP_REPORT) begin
      slot_live[w.peer_index]     = 1'b1;
      slot_level[w.peer_index]    = w.peer_stress;
      slot_heard_ms[w.peer_index] = w.now_ms;
      return;
    end
    if (w.stats_ready) begin
      seen_exec = w.exec_peak;
      seen_miss = w.miss_count;
    end
    if (seen_miss != 0) stress = STRESS_HI;
    else if (seen_exec > thr_exec || w.cpu_pct > thr_cpu) stress = STRESS_MED;
    else stress = STRESS_LO;

    // Age the peer table and gather the peer flags from the survivors
    low_peer  = 1'b0;
    high_peer = 1'b0;
    for (int i = 0; i < PEER_SLOTS; i++) begin
      if (slot_live[i]) begin
        if (ms_t'(w.now_ms - slot_heard_ms[i]) > {16'd0, slot_tmo}) begin
          slot_live[i] = 1'b0;
        end else begin
          if (shed_en && slot_level[i] == STRESS_LO) low_peer = 1'b1;
          if (slot_level[i] == STRESS_HI) high_peer = 1'b1;
        end
      end
    end

    v.load_change = CHANGE_NONE;
    if (w.stats_ready && ms_t'(w.now_ms - last_step_ms) >= {16'd0, step_gap_ms}) begin
      if (shed_en && stress == STRESS_HI && low_peer && w.active_channels == 0) begin
        // Step down, but never below the floor; at the floor keep the streak
        if (load_now > floor_load) begin
          next_load = (load_now > LOAD_STEP) ? int'(load_now) - LOAD_STEP : int'(floor_load);
          if (next_load < floor_load) next_load = floor_load;
          load_now      = 8'(next_load);
          last_step_ms  = w.now_ms;
          calm_run      = '0;
          v.load_change = CHANGE_DEC;
        end
      end else if (stress == STRESS_LO && !high_peer) begin
        if (calm_run != 8'hFF) calm_run++;
        if (calm_run >= calm_needed && load_now < ceil_load) begin
          next_load = int'(load_now) + LOAD_STEP;
          if (next_load > ceil_load) next_load = ceil_load;
          load_now      = 8'(next_load);
          last_step_ms  = w.now_ms;
          calm_run      = '0;
          v.load_change = CHANGE_INC;
        end
      end else begin
        calm_run = '0;
      end
    end

    v.stress_out      = stress;
    v.offload_request = (stress != STRESS_LO);
    if (seen_miss != 0) v.run_state = RUN_OVER;
    else if (w.cpu_pct >= SAT_CPU_PCT) v.run_state = RUN_SAT;
    else v.run_state = RUN_SCHED;
    v.load_out = load_now;
    verdicts_due.push_back(v);
  endfunction

  function automatic gov_word_t tick_word(input ms_t now, input logic rdy,
                                          input logic [15:0] ex, input logic [15:0] miss,
                                          input logic [6:0] cpu, input logic [3:0] chans);
    gov_word_t w;
    w                 = '0;
    w.opcode          = OP_TICK;
    w.now_ms          = now;
    w.stats_ready     = rdy;
    w.exec_peak       = ex;
    w.miss_count      = miss;
    w.cpu_pct         = cpu;
    w.active_channels = chans;
    return w;
  endfunction

  function automatic gov_word_t report_word(input ms_t now, input logic [2:0] idx,
                                            input level_t lvl);
    gov_word_t w;
    w             = '0;
    w.opcode      = OP_REPORT;
    w.now_ms      = now;
    w.peer_index  = idx;
    w.peer_stress = lvl;
    return w;
  endfunction

  // Mostly well-timed ticks and reports around a running clock, with some noise
  function automatic gov_word_t random_word();
    gov_word_t w;
    int        pick;
    int        gap;
    int        tmo;
    level_t    lvl;
    gap  = step_gap_ms;
    tmo  = slot_tmo;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      w.opcode          = 1'($urandom_range(0, 1));
      w.now_ms          = $urandom;
      w.stats_ready     = 1'($urandom_range(0, 1));
      w.exec_peak       = 16'($urandom);
      w.miss_count      = 16'($urandom);
      w.cpu_pct         = 7'($urandom_range(0, 100));
      w.active_channels = 4'($urandom_range(0, 8));
      w.peer_index      = 3'($urandom);
      w.peer_stress     = level_t'($urandom_range(0, 3));
      return w;
    end
    if (pick < 38) begin
      clock_ms += $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: lvl = STRESS_LO;
        5, 6:          lvl = STRESS_MED;
        7, 8:          lvl = STRESS_HI;
        default:       lvl = STRESS_UNUSED;
      endcase
      w = report_word(clock_ms, 3'($urandom), lvl);
      if ($urandom_range(0, 15) == 0) w.now_ms = clock_ms - $urandom_range(0, 2 * tmo + 100);
      return w;
    end
    clock_ms += (gap == 0) ? $urandom_range(0, 60) : $urandom_range(gap / 2, gap + gap / 2);
    if ($urandom_range(0, 24) == 0) clock_ms += $urandom_range(0, 3 * tmo + 1000);
    w = tick_word(clock_ms, ($urandom_range(0, 9) != 0),
                  ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, thr_exec))
                                             : 16'($urandom),
                  ($urandom_range(0, 9) < 7) ? 16'd0
                  : (($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535))),
                  ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, thr_cpu))
                                             : 7'($urandom_range(0, 100)),
                  ($urandom_range(0, 9) < 7) ? 4'd0 : 4'($urandom_range(0, 8)));
    w.peer_index  = 3'($urandom);
    w.peer_stress = level_t'($urandom_range(0, 3));
    return w;
  endfunction

  // Offer one word and hold it until taken; entered just after a rising edge
  task automatic send_word(input gov_word_t w);
    item_ch.valid           <= 1'b1;
    item_ch.opcode          <= w.opcode;
    item_ch.now_ms          <= w.now_ms;
    item_ch.stats_ready     <= w.stats_ready;
    item_ch.exec_peak       <= w.exec_peak;
    item_ch.miss_count      <= w.miss_count;
    item_ch.cpu_pct         <= w.cpu_pct;
    item_ch.active_channels <= w.active_channels;
    item_ch.peer_index      <= w.peer_index;
    item_ch.peer_stress     <= w.peer_stress;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    govern(w);
  endtask

  task automatic idle_sender(input int n);
    item_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering and wait for every outstanding verdict
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    shadow_config(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] e_thr, input logic [6:0] c_thr,
                               input logic [7:0] lo, input logic [7:0] hi,
                               input logic [7:0] wins, input logic [15:0] tmo,
                               input logic [15:0] gap, input logic den);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(REG_EXEC_THR, e_thr);
    cfg_write(REG_CPU_THR, {9'd0, c_thr});
    cfg_write(REG_LOAD_MIN, {8'd0, lo});
    cfg_write(REG_LOAD_MAX, {8'd0, hi});
    cfg_write(REG_LOW_WIN, {8'd0, wins});
    cfg_write(REG_PEER_TMO, tmo);
    cfg_write(REG_ADJ_INT, gap);
    cfg_write(REG_DEC_EN, {15'd0, den});
  endtask

  // Send words in bursts with random gaps, pausing now and then until drained
  task automatic run_stream(input int count);
    int burst_left;
    burst_left = 0;
    for (int k = 0; k < count; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
      end
      burst_left--;
      if ($urandom_range(0, 199) == 0) drain_results();
      send_word(random_word());
    end
  endtask

  // Receiver: pick a pace for a stretch, or hold off entirely when asked
  initial begin
    pace_t pace;
    int    pace_left;
    int    hold_left;
    pace      = PACE_FREE;
    pace_left = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else begin
        if (pace_left == 0) begin
          pace      = pace_t'($urandom_range(0, 3));
          pace_left = $urandom_range(20, 200);
        end
        pace_left--;
        case (pace)
          PACE_FREE:  result_ch.ready <= 1'b1;
          PACE_LIGHT: result_ch.ready <= ($urandom_range(0, 9) != 0);
          PACE_HALF:  result_ch.ready <= 1'($urandom_range(0, 1));
          default:    result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic bit field_differs(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Compare each accepted verdict with the oldest one predicted
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    bit       bad;
    if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got.stress_out      = result_ch.stress_out;
      got.offload_request = result_ch.offload_request;
      got.run_state       = result_ch.run_state;
      got.load_out        = result_ch.load_out;
      got.load_change     = result_ch.load_change;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected, got %p", $time, got);
      end else begin
        want = verdicts_due.pop_front();
        bad  = 1'b0;
        bad |= field_differs("stress_out", 8'(want.stress_out), 8'(got.stress_out));
        bad |= field_differs("offload_request", 8'(want.offload_request),
                             8'(got.offload_request));
        bad |= field_differs("run_state", 8'(want.run_state), 8'(got.run_state));
        bad |= field_differs("load_out", want.load_out, got.load_out);
        bad |= field_differs("load_change", 8'(want.load_change), 8'(got.load_change));
        if (bad) errors++;
      end
    end
  end

  // Walk the main rules under the reset settings
  task automatic test_directed();
    send_word(report_word(32'd1000, 3'd0, STRESS_LO));
    send_word(report_word(32'd1000, 3'd7, STRESS_UNUSED));
    send_word(tick_word(32'd2000, 1'b1, 16'd0, 16'd0, 7'd0, 4'd0));
    send_word(tick_word(32'd4000, 1'b1, 16'd0, 16'd0, 7'd0, 4'd0));
    send_word(tick_word(32'd6000, 1'b1, 16'd0, 16'd0, 7'd0, 4'd0));
    send_word(report_word(32'd7500, 3'd3, STRESS_LO));
    send_word(tick_word(32'd8000, 1'b1, 16'hFFFF, 16'hFFFF, 7'd100, 4'd0));
    // held statistics carry the miss; not ready, so no adjust
    send_word(tick_word(32'd9000, 1'b0, 16'd0, 16'd0, 7'd90, 4'd0));
    // decrease wanted at the floor: nothing moves
    send_word(tick_word(32'd11000, 1'b1, 16'd5, 16'd1, 7'd89, 4'd0));
    send_word(tick_word(32'd12000, 1'b1, 16'd5, 16'd1, 7'd20, 4'd8));
    send_word(tick_word(32'd14000, 1'b1, 16'hFFFF, 16'd0, 7'd50, 4'd0));
    send_word(tick_word(32'd16000, 1'b1, 16'd0, 16'd0, 7'd100, 4'd7));
    send_word(report_word(32'd16500, 3'd5, STRESS_HI));
    send_word(report_word(32'd16500, 3'd6, STRESS_MED));
    send_word(tick_word(32'd18000, 1'b1, 16'd100, 16'd0, 7'd85, 4'd0));
    // peer age exactly at the timeout survives, one more ms drops it
    send_word(report_word(32'd20000, 3'd1, STRESS_LO));
    send_word(tick_word(32'd25000, 1'b1, 16'd0, 16'd7, 7'd0, 4'd0));
    send_word(tick_word(32'd25001, 1'b1, 16'd0, 16'd7, 7'd0, 4'd0));
    // time wraps past the top of the range
    send_word(report_word(32'hFFFF_FF00, 3'd2, STRESS_LO));
    send_word(tick_word(32'hFFFF_FFFF, 1'b1, 16'd0, 16'd0, 7'd0, 4'd0));
    send_word(tick_word(32'd0, 1'b1, 16'd0, 16'd0, 7'd0, 4'd0));
    send_word(tick_word(32'd2500, 1'b1, 16'd0, 16'hFFFF, 7'd0, 4'd0));
    drain_results();
  endtask

  task automatic test_default_rates();
    apply_setting(16'd100, 7'd85, 8'd1, 8'd100, 8'd3, 16'd5000, 16'd2000, 1'b1);
    run_stream(250);
  endtask

  // Every threshold at its floor
  task automatic test_floor_settings();
    apply_setting(16'd0, 7'd0, 8'd0, 8'd255, 8'd1, 16'd0, 16'd0, 1'b1);
    run_stream(250);
  endtask

  // Every threshold at its ceiling, floor above ceiling, shedding off, time wrapping
  task automatic test_ceiling_settings();
    apply_setting(16'hFFFF, 7'd100, 8'd255, 8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 1'b0);
    clock_ms = 32'hFFF0_0000;
    run_stream(250);
  endtask

  task automatic test_no_shedding();
    apply_setting(16'd500, 7'd70, 8'd5, 8'd12, 8'd2, 16'd3000, 16'd500, 1'b0);
    run_stream(250);
  endtask

  task automatic test_random_settings();
    logic [7:0] lo;
    for (int p = 0; p < 3; p++) begin
      lo = 8'($urandom_range(0, 30));
      apply_setting(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)),
                    7'($urandom_range(0, 100)), lo, lo + 8'($urandom_range(0, 20)),
                    8'($urandom_range(1, 6)), 16'($urandom_range(500, 8000)),
                    16'($urandom_range(0, 3000)), 1'($urandom_range(0, 1)));
      clock_ms = $urandom;
      run_stream(150);
    end
  endtask

  // Stall the receiver long enough that the block backs up into its input
  task automatic test_backpressure();
    apply_setting(16'd300, 7'd80, 8'd2, 8'd40, 8'd1, 16'd4000, 16'd0, 1'b1);
    hold_off_req = 1'b1;
    for (int k = 0; k < 80; k++) send_word(random_word());
    drain_results();
  endtask

  // Writes to indexes past the last register must change nothing
  task automatic test_spare_registers();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) cfg_write(4'(i), 16'($urandom));
    run_stream(100);
  endtask

  initial begin
    errors       = 0;
    cycles       = 0;
    hold_off_req = 1'b0;
    clock_ms     = '0;
    shadow_reset();
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= '0;
    cfg_data                <= '0;
    item_ch.valid           <= 1'b0;
    item_ch.opcode          <= OP_TICK;
    item_ch.now_ms          <= '0;
    item_ch.stats_ready     <= 1'b0;
    item_ch.exec_peak       <= '0;
    item_ch.miss_count      <= '0;
    item_ch.cpu_pct         <= '0;
    item_ch.active_channels <= '0;
    item_ch.peer_index      <= '0;
    item_ch.peer_stress     <= STRESS_LO;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_default_rates();
    test_floor_settings();
    test_ceiling_settings();
    test_no_shedding();
    test_random_settings();
    test_backpressure();
    test_spare_registers();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** load_factor_governor: PASSED **");
    end else begin
      $display("** load_factor_governor: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/lfg_pkg.sv
design/lfg_item_if.sv
design/lfg_result_if.sv
design/lfg_peer_cell.sv
design/load_factor_governor.sv
tb/load_factor_governor_tb.sv
